@@ hw/rtl/ipds_pkg.sv @@
// ipds_pkg: shared widths, register codes, reset values and config struct
// for the divider search block; used by every module under hw/rtl
package ipds_pkg;

    localparam int TGT_W   = 29;
    localparam int XTAL_W  = 27;
    localparam int VCOL_W  = 32;
    localparam int DIV_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    localparam int PLL_MULT_FIRST_DEF = 25;
    localparam int PLL_MULT_LAST_DEF  = 36;

    localparam logic [DIV_W-1:0] DIV_MIN = 7'd6;
    localparam logic [DIV_W-1:0] DIV_MAX = 7'd127;

    localparam logic [CIDX_W-1:0] CFG_CRYSTAL = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_VCO_MIN = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_VCO_MAX = 2'd2;

    localparam logic [XTAL_W-1:0] CRYSTAL_RST = 27'd24576000;
    localparam logic [VCOL_W-1:0] VCO_MIN_RST = 32'd600000000;
    localparam logic [VCOL_W-1:0] VCO_MAX_RST = 32'd900000000;

    localparam logic [7:0]  MASK_QUAD   = 8'hF9;
    localparam logic [7:0]  MASK_SINGLE = 8'hFA;
    localparam logic [29:0] ACH_SAT     = 30'h3FFFFFFF;

    typedef struct packed {
        logic [XTAL_W-1:0] crystal;
        logic [VCOL_W-1:0] vco_min;
        logic [VCOL_W-1:0] vco_max;
    } t_cfg;

endpackage

@@ hw/rtl/ipds_lane.sv @@
// ipds_lane: one multiplier lane, vco window check, ideal divider by
// restoring division, three candidate dividers, f = vco/m and error; uses ipds_pkg
module ipds_lane
    import ipds_pkg::*;
#(
    parameter int P_MULT = PLL_MULT_FIRST_DEF,
    parameter bit P_USE  = 1'b1,
    parameter int VW     = XTAL_W + 6,
    parameter int LS     = 13 + (VW + 3) / 4
) (
    input  logic                 i_clk,
    input  logic [LS-1:0]        i_en,
    input  t_cfg                 i_cfg,
    input  logic [TGT_W-1:0]     i_tgt,
    output logic                 o_have,
    output logic [((VW > TGT_W+8) ? VW : TGT_W+8)-1:0] o_err,
    output logic [VW-1:0]        o_f,
    output logic [DIV_W-1:0]     o_m
);

    localparam int CW = (VW > TGT_W + 8) ? VW : TGT_W + 8;
    localparam int ND = (VW + 3) / 4;
    localparam int DW = ND * 4;
    localparam int SC = 10;
    localparam int SE = 11 + ND;
    localparam int SP = 12 + ND;

    // stage 0: vco product
    logic [VW-1:0]    r_vco0;
    logic [TGT_W-1:0] r_tgt0;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_vco0 <= VW'(P_MULT) * VW'(i_cfg.crystal);
            r_tgt0 <= i_tgt;
        end
    end

    // stage 1: window, quotient range, then eight quotient bit stages
    logic [CW-1:0]    r_rem  [0:8];
    logic [7:0]       r_q    [0:8];
    logic [VW-1:0]    r_vcoq [0:8];
    logic [TGT_W-1:0] r_tgtq [0:8];
    logic             r_ok   [0:8];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[0]  <= CW'(r_vco0);
            r_q[0]    <= '0;
            r_vcoq[0] <= r_vco0;
            r_tgtq[0] <= r_tgt0;
            r_ok[0]   <= P_USE
                && (64'(r_vco0) >= 64'(i_cfg.vco_min))
                && (64'(r_vco0) <= 64'(i_cfg.vco_max))
                && (CW'(r_vco0) < (CW'(r_tgt0) << 8));
        end
    end

    for (genvar i = 0; i < 8; i++) begin : g_qbit
        logic [CW-1:0] n_rem;
        logic [7:0]    n_q;
        logic [CW-1:0] dv;

        always_comb begin
            dv    = CW'(r_tgtq[i]) << (7 - i);
            n_rem = r_rem[i];
            n_q   = r_q[i];
            if (r_rem[i] >= dv) begin
                n_rem       = r_rem[i] - dv;
                n_q[7 - i]  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2 + i]) begin
                r_rem[i + 1]  <= n_rem;
                r_q[i + 1]    <= n_q;
                r_vcoq[i + 1] <= r_vcoq[i];
                r_tgtq[i + 1] <= r_tgtq[i];
                r_ok[i + 1]   <= r_ok[i];
            end
        end
    end

    // candidate dividers and f = vco / m, four quotient bits per stage
    logic [DW-1:0]    r_dvd  [0:ND];
    logic [7:0]       r_drem [0:ND][3];
    logic [DW-1:0]    r_fq   [0:ND][3];
    logic [DIV_W-1:0] r_m    [0:ND][3];
    logic             r_cv   [0:ND][3];
    logic [TGT_W-1:0] r_tgtd [0:ND];

    logic [8:0] ideal;
    logic [8:0] cand [3];
    logic       cok  [3];

    always_comb begin
        ideal   = {1'b0, r_q[8][7:1], 1'b0};
        cand[0] = ideal - 9'd2;
        cand[1] = ideal;
        cand[2] = ideal + 9'd2;
        for (int c = 0; c < 3; c++) begin
            cok[c] = r_ok[8] && (cand[c] >= 9'(DIV_MIN)) && (cand[c] <= 9'(DIV_MAX));
        end
        cok[0] = cok[0] && (ideal >= 9'd2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SC]) begin
            r_dvd[0]  <= DW'(r_vcoq[8]);
            r_tgtd[0] <= r_tgtq[8];
            for (int c = 0; c < 3; c++) begin
                r_drem[0][c] <= '0;
                r_fq[0][c]   <= '0;
                r_m[0][c]    <= cand[c][DIV_W-1:0];
                r_cv[0][c]   <= cok[c];
            end
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_fdiv
        logic [7:0]    rm [3];
        logic [DW-1:0] qq [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                rm[c] = r_drem[j][c];
                qq[c] = r_fq[j][c];
                for (int b = 0; b < 4; b++) begin
                    rm[c] = {rm[c][6:0], r_dvd[j][DW-1-b]};
                    qq[c] = {qq[c][DW-2:0], 1'b0};
                    if (rm[c] >= {1'b0, r_m[j][c]}) begin
                        rm[c]    = rm[c] - {1'b0, r_m[j][c]};
                        qq[c][0] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[SC + 1 + j]) begin
                r_dvd[j + 1]  <= {r_dvd[j][DW-5:0], 4'b0000};
                r_tgtd[j + 1] <= r_tgtd[j];
                for (int c = 0; c < 3; c++) begin
                    r_drem[j + 1][c] <= rm[c];
                    r_fq[j + 1][c]   <= qq[c];
                    r_m[j + 1][c]    <= r_m[j][c];
                    r_cv[j + 1][c]   <= r_cv[j][c];
                end
            end
        end
    end

    // absolute error
    logic [CW-1:0]    r_e_err [3];
    logic [VW-1:0]    r_e_f   [3];
    logic [DIV_W-1:0] r_e_m   [3];
    logic             r_e_cv  [3];
    logic [CW-1:0]    fe [3];
    logic [CW-1:0]    te;

    always_comb begin
        te = CW'(r_tgtd[ND]);
        for (int c = 0; c < 3; c++) begin
            fe[c] = CW'(r_fq[ND][c][VW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SE]) begin
            for (int c = 0; c < 3; c++) begin
                r_e_err[c] <= (fe[c] > te) ? (fe[c] - te) : (te - fe[c]);
                r_e_f[c]   <= r_fq[ND][c][VW-1:0];
                r_e_m[c]   <= r_m[ND][c];
                r_e_cv[c]  <= r_cv[ND][c];
            end
        end
    end

    // best of three, earlier kept on a tie
    logic             n_have;
    logic [CW-1:0]    n_err;
    logic [VW-1:0]    n_f;
    logic [DIV_W-1:0] n_m;

    always_comb begin
        n_have = 1'b0;
        n_err  = '0;
        n_f    = '0;
        n_m    = '0;
        for (int c = 0; c < 3; c++) begin
            if (r_e_cv[c] && (!n_have || r_e_err[c] < n_err)) begin
                n_have = 1'b1;
                n_err  = r_e_err[c];
                n_f    = r_e_f[c];
                n_m    = r_e_m[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SP]) begin
            o_have <= n_have;
            o_err  <= n_err;
            o_f    <= n_f;
            o_m    <= n_m;
        end
    end

endmodule

@@ hw/rtl/ipds_sel.sv @@
// ipds_sel: registered pairwise tree picking the lane with the smallest
// error, lower multiplier kept on a tie; uses ipds_pkg
module ipds_sel
    import ipds_pkg::*;
#(
    parameter int NL = 12,
    parameter int TL = 4,
    parameter int CW = 37,
    parameter int VW = 33
) (
    input  logic             i_clk,
    input  logic [TL-1:0]    i_en,
    input  logic             i_have [NL],
    input  logic [CW-1:0]    i_err  [NL],
    input  logic [VW-1:0]    i_f    [NL],
    input  logic [DIV_W-1:0] i_m    [NL],
    output logic             o_have,
    output logic [TL-1:0]    o_idx,
    output logic [VW-1:0]    o_f,
    output logic [DIV_W-1:0] o_m
);

    localparam int P2 = 1 << TL;

    logic             lv_have [0:TL][P2];
    logic [CW-1:0]    lv_err  [0:TL][P2];
    logic [VW-1:0]    lv_f    [0:TL][P2];
    logic [DIV_W-1:0] lv_m    [0:TL][P2];
    logic [TL-1:0]    lv_idx  [0:TL][P2];

    for (genvar j = 0; j < P2; j++) begin : g_leaf
        if (j < NL) begin : g_real
            assign lv_have[0][j] = i_have[j];
            assign lv_err[0][j]  = i_err[j];
            assign lv_f[0][j]    = i_f[j];
            assign lv_m[0][j]    = i_m[j];
        end else begin : g_pad
            assign lv_have[0][j] = 1'b0;
            assign lv_err[0][j]  = '0;
            assign lv_f[0][j]    = '0;
            assign lv_m[0][j]    = '0;
        end
        assign lv_idx[0][j] = TL'(j);
    end

    for (genvar l = 0; l < TL; l++) begin : g_lvl
        for (genvar j = 0; j < P2; j++) begin : g_node
            if (j < (P2 >> (l + 1))) begin : g_mrg
                logic take_r;
                assign take_r = lv_have[l][2*j+1]
                    && (!lv_have[l][2*j] || lv_err[l][2*j+1] < lv_err[l][2*j]);
                always_ff @(posedge i_clk) begin
                    if (i_en[l]) begin
                        lv_have[l+1][j] <= take_r ? 1'b1 : lv_have[l][2*j];
                        lv_err[l+1][j]  <= take_r ? lv_err[l][2*j+1] : lv_err[l][2*j];
                        lv_f[l+1][j]    <= take_r ? lv_f[l][2*j+1] : lv_f[l][2*j];
                        lv_m[l+1][j]    <= take_r ? lv_m[l][2*j+1] : lv_m[l][2*j];
                        lv_idx[l+1][j]  <= take_r ? lv_idx[l][2*j+1] : lv_idx[l][2*j];
                    end
                end
            end else begin : g_nil
                always_ff @(posedge i_clk) begin
                    if (i_en[l]) begin
                        lv_have[l+1][j] <= 1'b0;
                        lv_err[l+1][j]  <= '0;
                        lv_f[l+1][j]    <= '0;
                        lv_m[l+1][j]    <= '0;
                        lv_idx[l+1][j]  <= '0;
                    end
                end
            end
        end
    end

    assign o_have = lv_have[TL][0];
    assign o_idx  = lv_idx[TL][0];
    assign o_f    = lv_f[TL][0];
    assign o_m    = lv_m[TL][0];

endmodule

@@ hw/rtl/integer_pll_divider_search_top.sv @@
// integer_pll_divider_search_top: config registers, valid/stall pipeline
// control, multiplier lanes, selection tree and result register
// depends on ipds_pkg, ipds_lane, ipds_sel
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_stall    i_target_freq_hz, i_quadrature_mode
//  out       result     o_out_valid / i_out_stall  o_found .. o_output_disable_mask
//  cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request per cycle while o_in_stall is low; the pipeline depth is set by the
// eight-step ideal divider and the 4-bit-per-stage f divider
// every stage holds its own valid bit; a stage loads when empty or when the next
// stage moves, so bubbles close up under an output stall
// synchronous active-low reset clears valid bits and restores config defaults
module integer_pll_divider_search_top
    import ipds_pkg::*;
#(
    parameter int PLL_MULT_FIRST = PLL_MULT_FIRST_DEF,
    parameter int PLL_MULT_LAST  = PLL_MULT_LAST_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [TGT_W-1:0]    i_target_freq_hz,
    input  logic                i_quadrature_mode,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output logic [5:0]          o_pll_mult,
    output logic [DIV_W-1:0]    o_out_div,
    output logic [29:0]         o_achieved_freq_hz,
    output logic [12:0]         o_pll_p1_word,
    output logic [13:0]         o_div_p1_word,
    output logic [DIV_W-1:0]    o_phase_offset,
    output logic [7:0]          o_output_disable_mask,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CDATA_W-1:0]  i_cfg_data
);

    localparam bit USE  = (PLL_MULT_LAST >= PLL_MULT_FIRST);
    localparam int NL   = USE ? (PLL_MULT_LAST - PLL_MULT_FIRST + 1) : 1;
    localparam int MAXM = USE ? PLL_MULT_LAST : PLL_MULT_FIRST;
    localparam int NW   = $clog2(MAXM + 1);
    localparam int VW   = XTAL_W + NW;
    localparam int CW   = (VW > TGT_W + 8) ? VW : TGT_W + 8;
    localparam int LS   = 13 + (VW + 3) / 4;
    localparam int TL   = (NL > 1) ? $clog2(NL) : 1;
    localparam int NS   = LS + TL + 1;

    // configuration
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crystal <= CRYSTAL_RST;
            r_cfg.vco_min <= VCO_MIN_RST;
            r_cfg.vco_max <= VCO_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CRYSTAL: r_cfg.crystal <= i_cfg_data[XTAL_W-1:0];
                CFG_VCO_MIN: r_cfg.vco_min <= i_cfg_data;
                CFG_VCO_MAX: r_cfg.vco_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;
    logic          r_quad [NS-1];

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_quad[0] <= i_quadrature_mode;
        end
        for (int s = 1; s < NS - 1; s++) begin
            if (en[s]) begin
                r_quad[s] <= r_quad[s-1];
            end
        end
    end

    // lanes
    logic             l_have [NL];
    logic [CW-1:0]    l_err  [NL];
    logic [VW-1:0]    l_f    [NL];
    logic [DIV_W-1:0] l_m    [NL];

    for (genvar i = 0; i < NL; i++) begin : g_lane
        ipds_lane #(
            .P_MULT (PLL_MULT_FIRST + i),
            .P_USE  (USE),
            .VW     (VW),
            .LS     (LS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (en[LS-1:0]),
            .i_cfg  (r_cfg),
            .i_tgt  (i_target_freq_hz),
            .o_have (l_have[i]),
            .o_err  (l_err[i]),
            .o_f    (l_f[i]),
            .o_m    (l_m[i])
        );
    end

    logic             s_have;
    logic [TL-1:0]    s_idx;
    logic [VW-1:0]    s_f;
    logic [DIV_W-1:0] s_m;

    ipds_sel #(
        .NL (NL),
        .TL (TL),
        .CW (CW),
        .VW (VW)
    ) u_sel (
        .i_clk  (i_clk),
        .i_en   (en[LS+TL-1:LS]),
        .i_have (l_have),
        .i_err  (l_err),
        .i_f    (l_f),
        .i_m    (l_m),
        .o_have (s_have),
        .o_idx  (s_idx),
        .o_f    (s_f),
        .o_m    (s_m)
    );

    // result register
    logic [5:0] sel_mult;

    assign sel_mult = 6'(PLL_MULT_FIRST) + 6'(s_idx);

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            if (s_have) begin
                o_found               <= 1'b1;
                o_pll_mult            <= sel_mult;
                o_out_div             <= s_m;
                o_achieved_freq_hz    <= (64'(s_f) > 64'(ACH_SAT)) ? ACH_SAT : 30'(s_f);
                o_pll_p1_word         <= {sel_mult, 7'b0} - 13'd512;
                o_div_p1_word         <= {s_m, 7'b0} - 14'd512;
                o_phase_offset        <= r_quad[NS-2] ? s_m : '0;
                o_output_disable_mask <= r_quad[NS-2] ? MASK_QUAD : MASK_SINGLE;
            end else begin
                o_found               <= 1'b0;
                o_pll_mult            <= '0;
                o_out_div             <= '0;
                o_achieved_freq_hz    <= '0;
                o_pll_p1_word         <= '0;
                o_div_p1_word         <= '0;
                o_phase_offset        <= '0;
                o_output_disable_mask <= '0;
            end
        end
    end

    a_div_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_out_div[0] && o_out_div >= DIV_MIN)
        else $error("chosen divider out of range or odd");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_out_div == '0 && o_pll_mult == '0
            && o_output_disable_mask == '0 && o_achieved_freq_hz == '0)
        else $error("not-found result carries data");

    a_div_p1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_div_p1_word == ({o_out_div, 7'b0} - 14'd512))
        else $error("divider word does not match divider");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> !o_in_stall)
        else $error("empty first stage stalls requests");

endmodule

@@ test/tb_integer_pll_divider_search_top.sv @@
// tb_integer_pll_divider_search_top: self-checking bench for the divider search block
// random and directed retune requests checked against an in-bench search predictor
// depends on ipds_pkg and integer_pll_divider_search_top
module tb_integer_pll_divider_search_top;
    import ipds_pkg::*;

    typedef struct {
        logic [TGT_W-1:0] target;
        logic             quad;
    } t_req;

    typedef struct {
        logic        found;
        logic [5:0]  mult;
        logic [6:0]  div;
        logic [29:0] ach;
        logic [12:0] pll_p1;
        logic [13:0] div_p1;
        logic [6:0]  phase;
        logic [7:0]  mask;
    } t_tune;

    localparam longint DIR_VALS [13] = '{0, 1, 2, 7000000, 14000000, 1000000, 5000000,
                                         100000000, 150000000, 300000000, 536870911,
                                         4724000, 7074000};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [TGT_W-1:0]    i_target_freq_hz;
    logic                i_quadrature_mode;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_found;
    logic [5:0]          o_pll_mult;
    logic [DIV_W-1:0]    o_out_div;
    logic [29:0]         o_achieved_freq_hz;
    logic [12:0]         o_pll_p1_word;
    logic [13:0]         o_div_p1_word;
    logic [DIV_W-1:0]    o_phase_offset;
    logic [7:0]          o_output_disable_mask;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [CDATA_W-1:0]  i_cfg_data;

    t_req   pending_reqs[$];
    t_tune  expected_tunes[$];
    longint xtal_hz, vco_lo_hz, vco_hi_hz;
    int     errors;
    int     burst_left, gap_left;
    int     stall_phase;
    bit     hold_send;

    integer_pll_divider_search_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_tune search_divider(t_req r);
        t_tune  t;
        longint tgt, vco, ideal, m, f, err, min_err, best_n, best_m, ach;
        bit     have;
        t = '{default: '0};
        tgt = r.target;
        have = 0;
        min_err = 0;
        best_n = 0;
        best_m = 0;
        if (tgt == 0) return t;
        for (longint n = 25; n <= 36; n++) begin
            vco = n * xtal_hz;
            if (vco < vco_lo_hz || vco > vco_hi_hz) continue;
            ideal = (vco / tgt) & ~64'sd1;
            for (int d = 0; d < 3; d++) begin
                if (d == 0 && ideal < 2) continue;
                m = ideal + 2 * (d - 1);
                if (m < 6 || m > 127) continue;
                f = vco / m;
                err = (f > tgt) ? f - tgt : tgt - f;
                if (!have || err < min_err) begin
                    have = 1;
                    min_err = err;
                    best_n = n;
                    best_m = m;
                end
            end
        end
        if (!have) return t;
        ach = best_n * xtal_hz / best_m;
        if (ach > 64'h3FFFFFFF) ach = 64'h3FFFFFFF;
        t.found = 1'b1;
        t.mult = best_n[5:0];
        t.div = best_m[6:0];
        t.ach = ach[29:0];
        t.pll_p1 = 13'(128 * best_n - 512);
        t.div_p1 = 14'(128 * best_m - 512);
        t.phase = r.quad ? best_m[6:0] : 7'd0;
        t.mask = r.quad ? MASK_QUAD : MASK_SINGLE;
        return t;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error: %s got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver
    logic o_in_stall_q;
    always @(posedge i_clk) begin
        o_in_stall_q <= o_in_stall;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_stall_q)) begin
            if (gap_left > 0 || hold_send || pending_reqs.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                t_req r;
                r = pending_reqs.pop_front();
                expected_tunes.push_back(search_divider(r));
                i_target_freq_hz <= r.target;
                i_quadrature_mode <= r.quad;
                i_in_valid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
            end
        end
        stall_phase++;
        if (stall_phase[8]) i_out_stall <= 1'b0;
        else if (stall_phase[5]) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= (stall_phase[2:0] == 3'd5);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tunes.size() == 0) begin
                report_mismatch("unexpected result", o_found, 0);
            end else begin
                t_tune e;
                e = expected_tunes.pop_front();
                if (o_found !== e.found) report_mismatch("found", o_found, e.found);
                if (o_pll_mult !== e.mult) report_mismatch("pll_mult", o_pll_mult, e.mult);
                if (o_out_div !== e.div) report_mismatch("out_div", o_out_div, e.div);
                if (o_achieved_freq_hz !== e.ach)
                    report_mismatch("achieved_freq_hz", o_achieved_freq_hz, e.ach);
                if (o_pll_p1_word !== e.pll_p1)
                    report_mismatch("pll_p1_word", o_pll_p1_word, e.pll_p1);
                if (o_div_p1_word !== e.div_p1)
                    report_mismatch("div_p1_word", o_div_p1_word, e.div_p1);
                if (o_phase_offset !== e.phase)
                    report_mismatch("phase_offset", o_phase_offset, e.phase);
                if (o_output_disable_mask !== e.mask)
                    report_mismatch("output_disable_mask", o_output_disable_mask, e.mask);
            end
        end
    end

    task automatic write_reg(logic [CIDX_W-1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[31:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CRYSTAL: xtal_hz = val & 64'h7FFFFFF;
            CFG_VCO_MIN: vco_lo_hz = val & 64'hFFFFFFFF;
            CFG_VCO_MAX: vco_hi_hz = val & 64'hFFFFFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_tunes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_req rand_req(longint lo_hz, longint hi_hz);
        t_req r;
        longint v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 255);
            1: v = 300000000 - $urandom_range(0, 1000);
            2: v = {$urandom} & 32'h1FFFFFFF;
            default: v = lo_hz + ({$urandom} % (hi_hz - lo_hz + 1));
        endcase
        r.target = v[TGT_W-1:0];
        r.quad = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic run_random(int count, longint lo_hz, longint hi_hz);
        repeat (count) pending_reqs.push_back(rand_req(lo_hz, hi_hz));
        drain();
    endtask

    initial begin
        errors = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        hold_send = 0;
        xtal_hz = CRYSTAL_RST;
        vco_lo_hz = VCO_MIN_RST;
        vco_hi_hz = VCO_MAX_RST;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_target_freq_hz = '0;
        i_quadrature_mode = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CRYSTAL;
        i_cfg_data = '0;
        o_in_stall_q = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both modes, zero target, divider near zero
        foreach (DIR_VALS[k]) begin
            pending_reqs.push_back(t_req'{DIR_VALS[k][TGT_W-1:0], k[0]});
            pending_reqs.push_back(t_req'{DIR_VALS[k][TGT_W-1:0], ~k[0]});
        end
        drain();

        run_random(300, 1000000, 160000000);

        // hold off until everything has returned, then resume
        hold_send = 1;
        repeat (200) pending_reqs.push_back(rand_req(1000000, 160000000));
        while (expected_tunes.size() != 0) @(posedge i_clk);
        hold_send = 0;
        drain();

        write_reg(CFG_CRYSTAL, 100000000);
        write_reg(CFG_VCO_MIN, 0);
        write_reg(CFG_VCO_MAX, 64'hFFFFFFFF);
        run_random(200, 1, 300000000);

        write_reg(CFG_CRYSTAL, 1000000);
        write_reg(CFG_VCO_MIN, 30000000);
        run_random(100, 1, 6000000);

        // inverted (empty) window, then zero crystal
        write_reg(CFG_VCO_MIN, 64'hFFFFFFFF);
        write_reg(CFG_VCO_MAX, 0);
        run_random(50, 1, 10000000);
        write_reg(CFG_CRYSTAL, 0);
        write_reg(CFG_VCO_MIN, 0);
        run_random(50, 1, 10000000);

        write_reg(CFG_CRYSTAL, 27000000);
        write_reg(CFG_VCO_MIN, 600000000);
        write_reg(CFG_VCO_MAX, 900000000);
        run_random(300, 3000000, 150000000);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ integer_pll_divider_search_top.f @@
hw/rtl/ipds_pkg.sv
hw/rtl/ipds_lane.sv
hw/rtl/ipds_sel.sv
hw/rtl/integer_pll_divider_search_top.sv
test/tb_integer_pll_divider_search_top.sv
